@@ src/tgpq_pkg.sv @@
// Shared types, constants and helper functions of the touch gesture playback queue.
// Used by the point unit, sample store and top level; depends on nothing else.
package tgpq_pkg;

   localparam int QUEUE_DEPTH      = 32;
   localparam int SLOT_W           = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W          = $clog2(QUEUE_DEPTH + 1);
   localparam int STEP_W           = 4;
   localparam int COORD_W          = 16;
   localparam int SIZE_W           = 13;
   localparam int HOLD_W           = 31;
   localparam int TIME_W           = 32;
   localparam int REQ_DATA_W       = 128;
   localparam int RSP_DATA_W       = 48;

   localparam logic [HOLD_W-1:0] TAP_HOLD_MS      = HOLD_W'(50);
   localparam logic [HOLD_W-1:0] SWIPE_RELEASE_MS = HOLD_W'(40);
   localparam logic [HOLD_W-1:0] SWIPE_MIN_MS     = HOLD_W'(80);
   localparam int                SWIPE_STEPS      = 8;
   localparam int                SWIPE_SHIFT      = $clog2(SWIPE_STEPS);

   localparam logic [STEP_W-1:0] TAP_LAST_STEP    = STEP_W'(1);
   localparam logic [STEP_W-1:0] SWIPE_LAST_STEP  = STEP_W'(SWIPE_STEPS + 1);

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      REQ_TAP   = 2'd0,
      REQ_SWIPE = 2'd1,
      REQ_WAIT  = 2'd2,
      REQ_POLL  = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [HOLD_W-1:0]         hold;
      logic                      pressed;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } sample_type;

   typedef struct packed {
      req_kind_type              kind;
      logic signed [COORD_W-1:0] xs;
      logic signed [COORD_W-1:0] ys;
      logic signed [COORD_W-1:0] xe;
      logic signed [COORD_W-1:0] ye;
      logic signed [COORD_W:0]   dx;
      logic signed [COORD_W:0]   dy;
      logic [HOLD_W-1:0]         dur;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      sample_type        data;
   } store_wr_type;

   function automatic logic signed [COORD_W-1:0] clamp_axis(
      logic signed [COORD_W-1:0] v,
      logic [SIZE_W-1:0]         size
   );
      logic [SIZE_W-1:0]         top_m1;
      logic signed [COORD_W-1:0] top_s;
      logic signed [COORD_W-1:0] r;
      top_m1 = (size == '0) ? '0 : size - SIZE_W'(1);
      top_s  = $signed(COORD_W'(top_m1));
      if (v < 0) begin
         r = '0;
      end else if (v > top_s) begin
         r = top_s;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] interp_axis(
      logic signed [COORD_W-1:0] s,
      logic signed [COORD_W:0]   d,
      logic [STEP_W-1:0]         k
   );
      logic signed [COORD_W+STEP_W+1:0] p;
      logic signed [COORD_W+STEP_W+1:0] q;
      p = (COORD_W+STEP_W+2)'(d) * $signed((COORD_W+STEP_W+2)'(k));
      q = p[COORD_W+STEP_W+1] ? p + (COORD_W+STEP_W+2)'(SWIPE_STEPS - 1) : p;
      q = q >>> SWIPE_SHIFT;
      return s + q[COORD_W-1:0];
   endfunction

endpackage

@@ src/tgpq_point_unit.sv @@
// Shared sample generator: builds one queue sample per cycle for the step in hand.
// Depends on tgpq_pkg for the job, sample types and the clamp and interpolation functions.
module tgpq_point_unit (
   input  tgpq_pkg::job_type                   job,
   input  logic [tgpq_pkg::STEP_W-1:0]         step,
   input  logic signed [tgpq_pkg::COORD_W-1:0] cur_x,
   input  logic signed [tgpq_pkg::COORD_W-1:0] cur_y,
   input  logic [tgpq_pkg::SIZE_W-1:0]         screen_width,
   input  logic [tgpq_pkg::SIZE_W-1:0]         screen_height,
   output tgpq_pkg::sample_type                sample,
   output logic                                last_step
);

   logic [tgpq_pkg::HOLD_W-1:0] swipe_ms;
   logic [tgpq_pkg::HOLD_W-1:0] swipe_hold;

   always_comb begin
      swipe_ms   = (job.dur < tgpq_pkg::SWIPE_MIN_MS) ? tgpq_pkg::SWIPE_MIN_MS : job.dur;
      swipe_hold = swipe_ms >> tgpq_pkg::SWIPE_SHIFT;
      sample     = '0;
      last_step  = 1'b1;
      unique case (job.kind)
         tgpq_pkg::REQ_TAP: begin
            sample.x       = tgpq_pkg::clamp_axis(job.xs, screen_width);
            sample.y       = tgpq_pkg::clamp_axis(job.ys, screen_height);
            sample.pressed = (step == '0);
            sample.hold    = tgpq_pkg::TAP_HOLD_MS;
            last_step      = (step == tgpq_pkg::TAP_LAST_STEP);
         end
         tgpq_pkg::REQ_SWIPE: begin
            last_step = (step == tgpq_pkg::SWIPE_LAST_STEP);
            if (step == '0) begin
               sample.x       = job.xs;
               sample.y       = job.ys;
               sample.pressed = 1'b1;
               sample.hold    = swipe_hold;
            end else if (last_step) begin
               sample.x       = job.xe;
               sample.y       = job.ye;
               sample.pressed = 1'b0;
               sample.hold    = tgpq_pkg::SWIPE_RELEASE_MS;
            end else begin
               sample.x       = tgpq_pkg::interp_axis(job.xs, job.dx, step);
               sample.y       = tgpq_pkg::interp_axis(job.ys, job.dy, step);
               sample.pressed = 1'b1;
               sample.hold    = swipe_hold;
            end
         end
         tgpq_pkg::REQ_WAIT: begin
            sample.x       = cur_x;
            sample.y       = cur_y;
            sample.pressed = 1'b0;
            sample.hold    = job.dur;
         end
         default: begin
            sample    = '0;
            last_step = 1'b1;
         end
      endcase
   end

endmodule

@@ src/tgpq_sample_store.sv @@
// Sample queue storage: one write port and one registered read port.
// Depends on tgpq_pkg for the depth, slot width and sample layout.
module tgpq_sample_store (
   input  logic                              clock,
   input  tgpq_pkg::store_wr_type            wr,
   input  logic [tgpq_pkg::SLOT_W-1:0]       rd_slot,
   output tgpq_pkg::sample_type              rd_data
);

   tgpq_pkg::sample_type mem [tgpq_pkg::QUEUE_DEPTH];
   tgpq_pkg::sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.slot] <= wr.data;
      end
      rd_data_ff <= mem[rd_slot];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/touch_gesture_playback_queue_top.sv @@
// Top level of the touch gesture playback queue: sequencer, pointer state and ports.
// Depends on tgpq_pkg, tgpq_point_unit and tgpq_sample_store.
//
// Requests arrive as beats on the req_ channel (kind in req_tuser, points, duration
// and current tick in req_tdata); each gives exactly one response beat on rsp_.
// A tap, swipe or wait writes its samples into the queue one per cycle through the
// single point unit and store write port, dropping those that find the queue full;
// a poll reads the queue head, pops it when due and reports pointer ownership. The
// block takes one request at a time, passing through push or read and pop, then done,
// until req_tready rises again; the response beat is registered and appears in the
// same cycle in which req_tready returns.
// A finished response waits in its output register while the next request is
// accepted; the following response is held back until the waiting beat is taken.
// Screen size registers are written on the csr_ channel, which is always ready.
// Synchronous reset empties the queue, clears the pointer and due time, and sets
// the screen to 240 by 320; queue storage itself is not cleared.
module touch_gesture_playback_queue_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // x_start, y_start, x_end, y_end, duration_ms, now_ms, zero pad
   input  logic [tgpq_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // owns_pointer, point_x, point_y, pressed, samples_queued, queue_level, zero pad
   output logic [tgpq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [tgpq_pkg::SIZE_W-1:0]          csr_data
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PUSH = 5'b00010,
      S_READ = 5'b00100,
      S_POP  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type                            state_ff, state_in;
   tgpq_pkg::job_type                    job_ff, job_in;
   logic [tgpq_pkg::STEP_W-1:0]          step_ff, step_in;
   logic [3:0]                           count_ff, count_in;
   logic [tgpq_pkg::TIME_W-1:0]          now_ff, now_in;
   logic [tgpq_pkg::SIZE_W-1:0]          width_ff, width_in;
   logic [tgpq_pkg::SIZE_W-1:0]          height_ff, height_in;
   logic [tgpq_pkg::SLOT_W-1:0]          rd_slot_ff, rd_slot_in;
   logic [tgpq_pkg::SLOT_W-1:0]          wr_slot_ff, wr_slot_in;
   logic [tgpq_pkg::LEVEL_W-1:0]         fill_ff, fill_in;
   logic signed [tgpq_pkg::COORD_W-1:0]  cur_x_ff, cur_x_in;
   logic signed [tgpq_pkg::COORD_W-1:0]  cur_y_ff, cur_y_in;
   logic                                 cur_pr_ff, cur_pr_in;
   logic [tgpq_pkg::TIME_W-1:0]          due_ff, due_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [tgpq_pkg::RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   tgpq_pkg::sample_type                 sample;
   tgpq_pkg::sample_type                 head;
   tgpq_pkg::store_wr_type               wr;
   logic                                 last_step;
   logic                                 full;
   logic                                 owns;
   logic [tgpq_pkg::HOLD_W-1:0]          pop_hold;

   tgpq_point_unit u_point_unit (
      .job           (job_ff),
      .step          (step_ff),
      .cur_x         (cur_x_ff),
      .cur_y         (cur_y_ff),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .sample        (sample),
      .last_step     (last_step)
   );

   tgpq_sample_store u_sample_store (
      .clock   (clock),
      .wr      (wr),
      .rd_slot (rd_slot_ff),
      .rd_data (head)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign full     = (fill_ff == tgpq_pkg::LEVEL_W'(tgpq_pkg::QUEUE_DEPTH));
   assign pop_hold = (head.hold == '0) ? tgpq_pkg::HOLD_W'(1) : head.hold;

   always_comb begin
      wr.en   = (state_ff == S_PUSH) && !full;
      wr.slot = wr_slot_ff;
      wr.data = sample;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      now_in       = now_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rd_slot_in   = rd_slot_ff;
      wr_slot_in   = wr_slot_ff;
      fill_in      = fill_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_pr_in    = cur_pr_ff;
      due_in       = due_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      owns         = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tgpq_pkg::CSR_WIDTH:  width_in  = csr_data;
            tgpq_pkg::CSR_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               job_in.kind = tgpq_pkg::req_kind_type'(req_tuser);
               job_in.xs   = req_tdata[15:0];
               job_in.ys   = req_tdata[31:16];
               job_in.xe   = req_tdata[47:32];
               job_in.ye   = req_tdata[63:48];
               job_in.dx   = $signed({req_tdata[47], req_tdata[47:32]})
                           - $signed({req_tdata[15], req_tdata[15:0]});
               job_in.dy   = $signed({req_tdata[63], req_tdata[63:48]})
                           - $signed({req_tdata[31], req_tdata[31:16]});
               job_in.dur  = req_tdata[94:64];
               now_in      = req_tdata[126:95];
               step_in     = '0;
               count_in    = '0;
               state_in    = (req_tuser == tgpq_pkg::REQ_POLL) ? S_READ : S_PUSH;
            end
         end
         S_PUSH: begin
            if (!full) begin
               wr_slot_in = (wr_slot_ff == tgpq_pkg::SLOT_W'(tgpq_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_slot_ff + tgpq_pkg::SLOT_W'(1);
               fill_in    = fill_ff + tgpq_pkg::LEVEL_W'(1);
               count_in   = count_ff + 4'd1;
            end
            step_in = step_ff + tgpq_pkg::STEP_W'(1);
            if (last_step) begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            state_in = S_POP;
         end
         S_POP: begin
            if ((fill_ff != '0) && (now_ff >= due_ff)) begin
               rd_slot_in = (rd_slot_ff == tgpq_pkg::SLOT_W'(tgpq_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_slot_ff + tgpq_pkg::SLOT_W'(1);
               fill_in    = fill_ff - tgpq_pkg::LEVEL_W'(1);
               cur_x_in   = head.x;
               cur_y_in   = head.y;
               cur_pr_in  = head.pressed;
               due_in     = now_ff + tgpq_pkg::TIME_W'(pop_hold);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            owns = (job_ff.kind == tgpq_pkg::REQ_POLL)
                && ((fill_ff != '0) || cur_pr_ff || (now_ff < due_ff));
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, 6'(fill_ff), count_ff, cur_pr_ff,
                               cur_y_ff, cur_x_ff, owns};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= tgpq_pkg::SIZE_W'(240);
         height_ff    <= tgpq_pkg::SIZE_W'(320);
         rd_slot_ff   <= '0;
         wr_slot_ff   <= '0;
         fill_ff      <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cur_pr_ff    <= 1'b0;
         due_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rd_slot_ff   <= rd_slot_in;
         wr_slot_ff   <= wr_slot_in;
         fill_ff      <= fill_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         cur_pr_ff    <= cur_pr_in;
         due_ff       <= due_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      now_ff      <= now_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ src/tgpq_checker.sv @@
// Port-level checks for the touch gesture playback queue, bound to its top level.
// Depends only on the ports of touch_gesture_playback_queue_top.
module tgpq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // A stalled response beat must hold its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // The block works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one was in progress");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[37:34] <= 4'd10)
      else $error("samples_queued out of range");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[43:38] <= 6'd32)
      else $error("queue_level beyond queue depth");

   // Ownership is only reported by a poll, and a poll queues nothing.
   a_owner_no_queue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[37:34] == 4'd0)
      else $error("owning response also reports queued samples");

endmodule

bind touch_gesture_playback_queue_top tgpq_checker u_tgpq_checker (.*);

@@ test/tb_touch_gesture_playback_queue_top.sv @@
// Self-checking testbench for touch_gesture_playback_queue_top: directed table, then random
// gestures and polls over several screen sizes, checked against an in-bench pointer predictor.
// Depends on tgpq_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_touch_gesture_playback_queue_top;

   typedef struct packed {
      tgpq_pkg::req_kind_type              kind;
      logic signed [tgpq_pkg::COORD_W-1:0] xs;
      logic signed [tgpq_pkg::COORD_W-1:0] ys;
      logic signed [tgpq_pkg::COORD_W-1:0] xe;
      logic signed [tgpq_pkg::COORD_W-1:0] ye;
      logic [tgpq_pkg::HOLD_W-1:0]         dur;
      logic [tgpq_pkg::TIME_W-1:0]         now;
   } gesture_req_type;

   typedef struct packed {
      logic                                owns;
      logic signed [tgpq_pkg::COORD_W-1:0] px;
      logic signed [tgpq_pkg::COORD_W-1:0] py;
      logic                                pressed;
      logic [3:0]                          queued;
      logic [5:0]                          level;
   } pointer_report_type;

   typedef struct packed {
      gesture_req_type    req;
      logic               known;
      pointer_report_type want;
   } gesture_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam gesture_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd0},
        1'b1, '{1'b0, 16'd0, 16'd0, 1'b0, 4'd0, 6'd0}},
      '{'{tgpq_pkg::REQ_TAP, 16'h8000, 16'h7FFF, 16'h1234, 16'h5678, 31'd0, 32'd0},
        1'b1, '{1'b0, 16'd0, 16'd0, 1'b0, 4'd2, 6'd2}},
      '{'{tgpq_pkg::REQ_TAP, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 31'h7FFFFFFF,
          32'hFFFFFFFF},
        1'b1, '{1'b0, 16'd0, 16'd0, 1'b0, 4'd2, 6'd4}},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd0},
        1'b1, '{1'b1, 16'd0, 16'd319, 1'b1, 4'd0, 6'd3}},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd49},
        1'b1, '{1'b1, 16'd0, 16'd319, 1'b1, 4'd0, 6'd3}},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd50},
        1'b1, '{1'b1, 16'd0, 16'd319, 1'b0, 4'd0, 6'd2}},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd100},
        1'b1, '{1'b1, 16'd239, 16'd0, 1'b1, 4'd0, 6'd1}},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd150},
        1'b1, '{1'b1, 16'd239, 16'd0, 1'b0, 4'd0, 6'd0}},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd199},
        1'b1, '{1'b1, 16'd239, 16'd0, 1'b0, 4'd0, 6'd0}},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd200},
        1'b1, '{1'b0, 16'd239, 16'd0, 1'b0, 4'd0, 6'd0}},
      '{'{tgpq_pkg::REQ_WAIT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd0},
        1'b1, '{1'b0, 16'd239, 16'd0, 1'b0, 4'd1, 6'd1}},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0,
          32'hFFFFFFFF},
        1'b1, '{1'b0, 16'd239, 16'd0, 1'b0, 4'd0, 6'd0}},
      '{'{tgpq_pkg::REQ_SWIPE, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 31'd0, 32'd0},
        1'b0, '0},
      '{'{tgpq_pkg::REQ_SWIPE, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 31'h7FFFFFFF,
          32'd0},
        1'b0, '0},
      '{'{tgpq_pkg::REQ_SWIPE, 16'h0000, 16'h0000, 16'h0007, 16'hFFF9, 31'd79, 32'd0},
        1'b0, '0},
      '{'{tgpq_pkg::REQ_TAP, 16'd240, 16'd320, 16'h0000, 16'h0000, 31'd0, 32'd0},
        1'b0, '0},
      '{'{tgpq_pkg::REQ_TAP, 16'd5, 16'd5, 16'h0000, 16'h0000, 31'd0, 32'd0},
        1'b1, '{1'b0, 16'd239, 16'd0, 1'b0, 4'd0, 6'd32}},
      '{'{tgpq_pkg::REQ_SWIPE, 16'd1, 16'd1, 16'd2, 16'd2, 31'd100, 32'd0},
        1'b1, '{1'b0, 16'd239, 16'd0, 1'b0, 4'd0, 6'd32}},
      '{'{tgpq_pkg::REQ_WAIT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'h7FFFFFFF,
          32'd0},
        1'b1, '{1'b0, 16'd239, 16'd0, 1'b0, 4'd0, 6'd32}},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd0},
        1'b0, '0},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd5},
        1'b0, '0},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd10},
        1'b0, '0},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0, 32'd20},
        1'b0, '0},
      '{'{tgpq_pkg::REQ_SWIPE, 16'd10, 16'd10, 16'hFFF6, 16'd20, 31'd160, 32'd0},
        1'b0, '0},
      '{'{tgpq_pkg::REQ_POLL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 31'd0,
          32'h7FFFFFFF},
        1'b0, '0}
   };

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [tgpq_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   logic [1:0]                          req_tuser = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [tgpq_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic                                csr_index = 1'b0;
   logic [tgpq_pkg::SIZE_W-1:0]         csr_data = '0;

   tgpq_pkg::sample_type                playback_queue[$];
   pointer_report_type                  pending_reports[$];
   logic signed [tgpq_pkg::COORD_W-1:0] pointer_x = '0;
   logic signed [tgpq_pkg::COORD_W-1:0] pointer_y = '0;
   logic                                pointer_pressed = 1'b0;
   logic [tgpq_pkg::TIME_W-1:0]         due_ms = '0;
   logic [tgpq_pkg::SIZE_W-1:0]         screen_w = tgpq_pkg::SIZE_W'(240);
   logic [tgpq_pkg::SIZE_W-1:0]         screen_h = tgpq_pkg::SIZE_W'(320);
   logic [tgpq_pkg::TIME_W-1:0]         sim_ms = '0;
   bit                                  sender_calm = 1'b0;
   bit                                  receiver_calm = 1'b0;
   int                                  stall_left = 0;
   int                                  mismatches = 0;

   touch_gesture_playback_queue_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic signed [tgpq_pkg::COORD_W-1:0] fit_axis(
      logic signed [tgpq_pkg::COORD_W-1:0] v,
      logic [tgpq_pkg::SIZE_W-1:0]         size
   );
      int top;
      int vi;
      top = (size == '0) ? 1 : int'(size);
      vi = v;
      if (vi < 0) vi = 0;
      if (vi > top - 1) vi = top - 1;
      return tgpq_pkg::COORD_W'(vi);
   endfunction

   function automatic int queue_sample(logic signed [tgpq_pkg::COORD_W-1:0] x,
                                       logic signed [tgpq_pkg::COORD_W-1:0] y,
                                       logic pr, logic [tgpq_pkg::HOLD_W-1:0] hold);
      if (playback_queue.size() >= tgpq_pkg::QUEUE_DEPTH) return 0;
      playback_queue.push_back('{hold, pr, y, x});
      return 1;
   endfunction

   function automatic pointer_report_type play_request(gesture_req_type r);
      pointer_report_type rep;
      tgpq_pkg::sample_type head;
      logic signed [tgpq_pkg::COORD_W-1:0] tx;
      logic signed [tgpq_pkg::COORD_W-1:0] ty;
      logic [tgpq_pkg::HOLD_W-1:0] ms;
      logic [tgpq_pkg::HOLD_W-1:0] hold;
      int count;
      count = 0;
      rep.owns = 1'b0;
      case (r.kind)
         tgpq_pkg::REQ_TAP: begin
            tx = fit_axis(r.xs, screen_w);
            ty = fit_axis(r.ys, screen_h);
            count += queue_sample(tx, ty, 1'b1, tgpq_pkg::TAP_HOLD_MS);
            count += queue_sample(tx, ty, 1'b0, tgpq_pkg::TAP_HOLD_MS);
         end
         tgpq_pkg::REQ_SWIPE: begin
            ms = (r.dur < tgpq_pkg::SWIPE_MIN_MS) ? tgpq_pkg::SWIPE_MIN_MS : r.dur;
            hold = ms / tgpq_pkg::SWIPE_STEPS;
            count += queue_sample(r.xs, r.ys, 1'b1, hold);
            for (int k = 1; k <= tgpq_pkg::SWIPE_STEPS; k++) begin
               tx = tgpq_pkg::COORD_W'(int'(r.xs)
                    + (int'(r.xe) - int'(r.xs)) * k / tgpq_pkg::SWIPE_STEPS);
               ty = tgpq_pkg::COORD_W'(int'(r.ys)
                    + (int'(r.ye) - int'(r.ys)) * k / tgpq_pkg::SWIPE_STEPS);
               count += queue_sample(tx, ty, 1'b1, hold);
            end
            count += queue_sample(r.xe, r.ye, 1'b0, tgpq_pkg::SWIPE_RELEASE_MS);
         end
         tgpq_pkg::REQ_WAIT: begin
            count += queue_sample(pointer_x, pointer_y, 1'b0, r.dur);
         end
         default: begin
            if (playback_queue.size() > 0 && r.now >= due_ms) begin
               head = playback_queue.pop_front();
               pointer_x = head.x;
               pointer_y = head.y;
               pointer_pressed = head.pressed;
               due_ms = r.now + ((head.hold == '0) ? tgpq_pkg::TIME_W'(1)
                                                   : tgpq_pkg::TIME_W'(head.hold));
            end
            rep.owns = (playback_queue.size() > 0) || pointer_pressed || (r.now < due_ms);
         end
      endcase
      rep.px = pointer_x;
      rep.py = pointer_y;
      rep.pressed = pointer_pressed;
      rep.queued = 4'(count);
      rep.level = 6'(playback_queue.size());
      return rep;
   endfunction

   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic signed [tgpq_pkg::COORD_W-1:0] pick_coord(
      logic [tgpq_pkg::SIZE_W-1:0] size
   );
      if ($urandom_range(0, 9) < 6)
         return tgpq_pkg::COORD_W'(int'($urandom_range(0, int'(size) + 40)) - 20);
      return tgpq_pkg::COORD_W'($urandom);
   endfunction

   function automatic logic [tgpq_pkg::HOLD_W-1:0] pick_duration();
      if ($urandom_range(0, 19) == 0) return tgpq_pkg::HOLD_W'($urandom);
      return tgpq_pkg::HOLD_W'($urandom_range(0, 400));
   endfunction

   function automatic gesture_req_type make_random_request(int poll_pct);
      gesture_req_type r;
      int pick;
      int tick_move;
      r.xs = pick_coord(screen_w);
      r.ys = pick_coord(screen_h);
      r.xe = pick_coord(screen_w);
      r.ye = pick_coord(screen_h);
      r.dur = pick_duration();
      r.now = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < poll_pct) begin
         r.kind = tgpq_pkg::REQ_POLL;
         tick_move = $urandom_range(0, 99);
         if (tick_move < 70) sim_ms += $urandom_range(0, 60);
         else if (tick_move < 90) sim_ms += $urandom_range(0, 400);
         else if (tick_move < 95) sim_ms = $urandom;
         if (tick_move < 97) r.now = sim_ms;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 45) r.kind = tgpq_pkg::REQ_TAP;
         else if (pick < 80) r.kind = tgpq_pkg::REQ_SWIPE;
         else r.kind = tgpq_pkg::REQ_WAIT;
      end
      return r;
   endfunction

   task automatic send_req(input gesture_req_type r, input logic known,
                           input pointer_report_type typed, input logic last_beat);
      pointer_report_type predicted;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= r.kind;
      req_tdata <= {1'b0, r.now, r.dur, r.ye, r.xe, r.ys, r.xs};
      do @(posedge clock); while (!req_tready);
      predicted = play_request(r);
      pending_reports.push_back(known ? typed : predicted);
      gap = pick_gap(sender_calm);
      if (last_beat || gap != 0) req_tvalid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic write_screen(input logic [tgpq_pkg::SIZE_W-1:0] w,
                               input logic [tgpq_pkg::SIZE_W-1:0] h);
      csr_valid <= 1'b1;
      csr_index <= tgpq_pkg::CSR_WIDTH;
      csr_data <= w;
      do @(posedge clock); while (!csr_ready);
      screen_w = w;
      csr_index <= tgpq_pkg::CSR_HEIGHT;
      csr_data <= h;
      do @(posedge clock); while (!csr_ready);
      screen_h = h;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!receiver_calm && $urandom_range(0, 99) < 25) begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(4, 40)
                                                    : $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pointer_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: response beat %h with none expected", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            check_field("owns_pointer", want.owns, rsp_tdata[0]);
            check_field("point_x", want.px, $signed(rsp_tdata[16:1]));
            check_field("point_y", want.py, $signed(rsp_tdata[32:17]));
            check_field("pressed", want.pressed, rsp_tdata[33]);
            check_field("samples_queued", want.queued, rsp_tdata[37:34]);
            check_field("queue_level", want.level, rsp_tdata[43:38]);
         end
      end
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [tgpq_pkg::SIZE_W-1:0] w;
      logic [tgpq_pkg::SIZE_W-1:0] h;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_req(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].want,
                  i == DIRECTED_ROWS - 1);
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         case (phase)
            0: begin w = 13'd1;    h = 13'd4096; end
            1: begin w = 13'd4096; h = 13'd1;    end
            2: begin w = 13'd0;    h = 13'd8191; end
            3: begin w = 13'd8191; h = 13'd0;    end
            4: begin w = 13'd240;  h = 13'd320;  end
            default: begin
               w = tgpq_pkg::SIZE_W'($urandom);
               h = tgpq_pkg::SIZE_W'($urandom);
            end
         endcase
         write_screen(w, h);
         sender_calm = (phase == 5);
         receiver_calm = (phase == 6);
         for (int n = 0; n < 250; n++)
            send_req(make_random_request(50 + 10 * (phase % 4)), 1'b0, '0, n == 249);
      end
      wait_idle();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/tgpq_pkg.sv
src/tgpq_point_unit.sv
src/tgpq_sample_store.sv
src/touch_gesture_playback_queue_top.sv
src/tgpq_checker.sv
test/tb_touch_gesture_playback_queue_top.sv
